// ===== rtl/sha1_pkg.sv =====
// SHA-1 digest package: shared types, constants and round helpers.
// Used by all sha1_* modules; no dependencies.
`default_nettype none
package sha1_pkg;
   localparam logic [31:0] H_INIT [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                          32'h10325476, 32'hC3D2E1F0};
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam int QDEPTH = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_LEN, ST_COMP, ST_OUT
   } state_type;

   function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (r < 7'd20) f = (b & c) | (~b & d);
      else if (r < 7'd40) f = b ^ c ^ d;
      else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
      else f = b ^ c ^ d;
      return f;
   endfunction

   function automatic logic [31:0] round_k(input logic [6:0] r);
      logic [31:0] k;
      if (r < 7'd20) k = K0;
      else if (r < 7'd40) k = K1;
      else if (r < 7'd60) k = K2;
      else k = K3;
      return k;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/sha1_front.sv =====
// SHA-1 front end: accepts stream transfers, drops idle items, queues the rest.
// Depends on sha1_pkg.
`default_nettype none
module sha1_front import sha1_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [7:0]  req_tdata,   // data_byte
   input  wire        req_tuser,   // byte_present
   input  wire        req_tlast,   // message_end
   output logic       q_valid,
   input  wire        q_pop,
   output item_type   q_item
);
   localparam int AW = $clog2(QDEPTH);
   item_type mem_ff [QDEPTH];
   logic [AW-1:0] wp_ff, rp_ff, wp_in, rp_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic push;

   assign req_tready = (cnt_ff != QDEPTH[AW:0]);
   // items with neither a byte nor an end do nothing; they are not queued
   assign push = req_tvalid && req_tready && (req_tuser || req_tlast);
   assign q_valid = (cnt_ff != '0);
   assign q_item = mem_ff[rp_ff];

   always_comb begin
      wp_in = push ? wp_ff + 1'b1 : wp_ff;
      rp_in = (q_pop && q_valid) ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + {{AW{1'b0}}, push} - {{AW{1'b0}}, (q_pop && q_valid)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= '{req_tdata, req_tuser, req_tlast};
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= QDEPTH)
      else $error("queue overflow");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == QDEPTH[AW:0]) && !q_pop |=> cnt_ff == QDEPTH[AW:0])
      else $error("count changed while full");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      !q_valid |-> !(q_pop && q_valid)) else $error("pop from empty");
endmodule
`default_nettype wire

// ===== rtl/sha1_back.sv =====
// SHA-1 back end: block packing, padding, 80-round compression, digest output.
// Depends on sha1_pkg.
`default_nettype none
module sha1_back import sha1_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire         q_valid,
   output logic        q_pop,
   input  item_type    q_item,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,  // digest_word, word_index, zero fill
   output logic        rsp_tlast   // last_word
);
   state_type st_ff, st_in;
   logic [31:0] buf_ff [16];
   logic [31:0] w_ff [16];
   logic [31:0] h_ff [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [60:0] cnt_ff;
   logic [6:0]  rnd_ff;
   logic [5:0]  pos_ff;       // padding write position
   logic        fin_ff;       // compression in progress is the final one
   logic [2:0]  idx_ff;
   logic [63:0] bits_ff;

   logic [5:0]  bpos;
   logic [3:0]  slot;
   logic [31:0] wx, wr, tsum;

   assign bpos = cnt_ff[5:0];
   assign slot = rnd_ff[3:0];
   assign q_pop = (st_ff == ST_IDLE) && q_valid;

   always_comb begin
      wx = w_ff[slot + 4'd13] ^ w_ff[slot + 4'd8] ^ w_ff[slot + 4'd2] ^ w_ff[slot];
      wr = (rnd_ff >= 7'd16) ? {wx[30:0], wx[31]} : w_ff[slot];
      tsum = {a_ff[26:0], a_ff[31:27]} + round_f(rnd_ff, b_ff, c_ff, d_ff) + e_ff
             + round_k(rnd_ff) + wr;
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (q_valid) begin
            if (q_item.byte_present && bpos == 6'd63) st_in = ST_COMP;
            else if (q_item.message_end) st_in = ST_PAD;
         end
         ST_PAD: if (pos_ff == 6'd63) st_in = ST_COMP;
            else if (pos_ff == 6'd55) st_in = ST_LEN;
         ST_LEN: st_in = ST_COMP;
         ST_COMP: if (rnd_ff == 7'd79) begin
            if (fin_ff) st_in = ST_OUT;
            else if (pos_ff == 6'd63) st_in = ST_PAD;
            else st_in = ST_IDLE;
         end
         ST_OUT: if (rsp_tready && idx_ff == 3'd4) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = (st_ff == ST_OUT);
   assign rsp_tdata = {5'd0, idx_ff, h_ff[idx_ff]};
   assign rsp_tlast = (idx_ff == 3'd4);

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) h_ff[i] <= H_INIT[i];
         cnt_ff <= '0;
         rnd_ff <= '0;
         pos_ff <= '0;
         fin_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         unique case (st_ff)
            ST_IDLE: if (q_valid) begin
               fin_ff <= 1'b0;
               if (q_item.byte_present) begin
                  buf_ff[bpos[5:2]][8*(3-bpos[1:0]) +: 8] <= q_item.data_byte;
                  cnt_ff <= cnt_ff + 61'd1;
               end
               if (q_item.message_end)
                  bits_ff <= {(cnt_ff + {60'd0, q_item.byte_present}), 3'b000};
               if (q_item.byte_present && bpos == 6'd63) begin
                  rnd_ff <= '0;
                  // 63 flags that padding still follows after this block
                  pos_ff <= q_item.message_end ? 6'd63 : 6'd0;
               end else if (q_item.message_end) begin
                  // padding begins at the next free byte position
                  pos_ff <= cnt_ff[5:0] + {5'd0, q_item.byte_present};
               end else begin
                  pos_ff <= 6'd0;
               end
            end
            ST_PAD: begin
               // first pad byte is 0x80 exactly when it sits at the byte count
               buf_ff[pos_ff[5:2]][8*(3-pos_ff[1:0]) +: 8] <=
                  (pos_ff == cnt_ff[5:0] && !bits_ff[0]) ? PAD_BYTE : 8'd0;
               if (pos_ff == cnt_ff[5:0]) bits_ff[0] <= 1'b1;
               // holding 63 tells the compression that a length block follows
               pos_ff <= (pos_ff == 6'd63) ? pos_ff : pos_ff + 6'd1;
               rnd_ff <= '0;
            end
            ST_LEN: begin
               buf_ff[14] <= bits_ff[63:32];
               buf_ff[15] <= {bits_ff[31:3], 3'b000};
               fin_ff <= 1'b1;
               rnd_ff <= '0;
            end
            ST_COMP: begin
               if (rnd_ff == 7'd0) begin
                  for (int i = 0; i < 16; i++) w_ff[i] <= buf_ff[i];
               end
               if (rnd_ff >= 7'd16) w_ff[slot] <= wr;
               if (rnd_ff == 7'd79) begin
                  rnd_ff <= '0;
                  h_ff[0] <= h_ff[0] + tsum;
                  h_ff[1] <= h_ff[1] + a_ff;
                  h_ff[2] <= h_ff[2] + {b_ff[1:0], b_ff[31:2]};
                  h_ff[3] <= h_ff[3] + c_ff;
                  h_ff[4] <= h_ff[4] + d_ff;
                  idx_ff <= '0;
                  if (pos_ff == 6'd63) pos_ff <= 6'd0;
               end else rnd_ff <= rnd_ff + 7'd1;
            end
            ST_OUT: if (rsp_tready) begin
               if (idx_ff == 3'd4) begin
                  for (int i = 0; i < 5; i++) h_ff[i] <= H_INIT[i];
                  cnt_ff <= '0;
                  idx_ff <= '0;
               end else begin
                  idx_ff <= idx_ff + 3'd1;
               end
            end
            default: ;
         endcase
      end
   end

   // working variables; round 0 reads the chain and buffer directly
   logic [31:0] ra, rb, rc, rd, re, w0, t0;
   always_comb begin
      ra = (rnd_ff == 7'd0) ? h_ff[0] : a_ff;
      rb = (rnd_ff == 7'd0) ? h_ff[1] : b_ff;
      rc = (rnd_ff == 7'd0) ? h_ff[2] : c_ff;
      rd = (rnd_ff == 7'd0) ? h_ff[3] : d_ff;
      re = (rnd_ff == 7'd0) ? h_ff[4] : e_ff;
      w0 = (rnd_ff == 7'd0) ? buf_ff[0] : wr;
      t0 = {ra[26:0], ra[31:27]} + round_f(rnd_ff, rb, rc, rd) + re + round_k(rnd_ff) + w0;
   end
   always_ff @(posedge clock) begin
      if (st_ff == ST_COMP) begin
         a_ff <= t0;
         b_ff <= ra;
         c_ff <= {rb[1:0], rb[31:2]};
         d_ff <= rc;
         e_ff <= rd;
      end
   end

   a_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> idx_ff <= 3'd4) else $error("bad word index");
   a_rnd: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_COMP |-> rnd_ff == 7'd0) else $error("round count left over");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> st_ff != ST_OUT) else $error("output without compression");
endmodule
`default_nettype wire

// ===== rtl/sha1_digest_top.sv =====
// SHA-1 digest top level: front queue plus compression back end.
// Depends on sha1_pkg, sha1_front, sha1_back.
//  channel | dir | tdata                                  | tuser / tlast
//  req     | in  | [7:0] data_byte                        | tuser byte_present, tlast message_end
//  rsp     | out | [31:0] digest_word, [34:32] word_index | tlast last_word
// Each byte goes into the block buffer; the 64th byte of a block starts 80 compression
// rounds (one round per cycle in the back end), padding writes the fill bytes and then the
// length and runs one or two compressions, then five digest transfers follow. A four-entry
// queue keeps accepting while the back end works and stalls req_tready when full;
// rsp_tready low holds the back end. Reset is synchronous.
`default_nettype none
module sha1_digest_top import sha1_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [7:0]   req_tdata,  // data_byte
   input  wire         req_tuser,  // byte_present
   input  wire         req_tlast,  // message_end
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,  // digest_word, word_index, zero fill
   output logic        rsp_tlast   // last_word
);
   logic q_valid, q_pop;
   item_type q_item;

   sha1_front u_front (.clock, .reset, .req_tvalid, .req_tready, .req_tdata,
                       .req_tuser, .req_tlast, .q_valid, .q_pop, .q_item);
   sha1_back u_back (.clock, .reset, .q_valid, .q_pop, .q_item, .rsp_tvalid,
                     .rsp_tready, .rsp_tdata, .rsp_tlast);
endmodule
`default_nettype wire
